// File: rtl/core/mtsea_pkg.sv
// mtsea_pkg: types, event codes and sizes for the multitouch slot event assembler
// no dependencies
`timescale 1ns / 1ps

package mtsea_pkg;

  localparam int NUM_SLOTS  = 32;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int OUT_SLOT_W = 5;
  localparam int NUM_FIELDS = 10;
  localparam int FIELD_W    = $clog2(NUM_FIELDS);

  localparam logic [15:0] EV_SYNC     = 16'h0000;
  localparam logic [15:0] EV_ABSOLUTE = 16'h0003;

  localparam logic [15:0] CODE_REPORT      = 16'h0000;
  localparam logic [15:0] CODE_SLOT        = 16'h002f;
  localparam logic [15:0] CODE_TOUCH_MAJOR = 16'h0030;
  localparam logic [15:0] CODE_TOUCH_MINOR = 16'h0031;
  localparam logic [15:0] CODE_WIDTH_MAJOR = 16'h0032;
  localparam logic [15:0] CODE_WIDTH_MINOR = 16'h0033;
  localparam logic [15:0] CODE_ORIENTATION = 16'h0034;
  localparam logic [15:0] CODE_POS_X       = 16'h0035;
  localparam logic [15:0] CODE_POS_Y       = 16'h0036;
  localparam logic [15:0] CODE_TRACK_ID    = 16'h0039;
  localparam logic [15:0] CODE_PRESSURE    = 16'h003a;
  localparam logic [15:0] CODE_DISTANCE    = 16'h003b;

  typedef enum logic [FIELD_W-1:0] {
    FLD_ID,
    FLD_X,
    FLD_Y,
    FLD_MAJOR,
    FLD_MINOR,
    FLD_WMAJOR,
    FLD_WMINOR,
    FLD_ANGLE,
    FLD_PRESSURE,
    FLD_DISTANCE
  } field_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_REPORT,
    OP_SLOT
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } event_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot_index;
    logic signed [31:0]    tracking_id;
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic signed [31:0]    contact_major;
    logic signed [31:0]    contact_minor;
    logic signed [31:0]    approach_major;
    logic signed [31:0]    approach_minor;
    logic signed [31:0]    contact_angle;
    logic signed [31:0]    contact_pressure;
    logic signed [31:0]    hover_distance;
  } result_t;

  typedef struct packed {
    op_e                op;
    field_e             field;
    logic [SLOT_W-1:0]  slot_sel;
    logic [31:0]        value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic    push;
    result_t rpt;
  } rpt_push_t;

endpackage

// File: rtl/core/multitouch_slot_event_assembler_top.sv
// multitouch_slot_event_assembler_top: multitouch slot event assembler
// depends on mtsea_pkg, mtsea_front, mtsea_back, mtsea_out_queue
//
//   channel   handshake     payload
//   events    push / full   evt (event_t: event_type, event_code, event_value)
//   reports   empty / pop   rpt (result_t: slot_index and ten contact fields)
//
// each command passes through the back-end states BK_IDLE and BK_EXEC: BK_IDLE
// pops it while the slot record is read from the per-field memories, BK_EXEC
// writes a field or emits the record. ignored items never reach the command queue.
// rst is synchronous; after it the back end sets all NUM_SLOTS records to -1
// in BK_CLEAR before it takes a command; the command queue still fills.
// a full report queue stalls emitting commands; the command queue keeps filling.
`timescale 1ns / 1ps

module multitouch_slot_event_assembler_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mtsea_pkg::event_t  evt,
  output logic               empty,
  input  logic               pop,
  output mtsea_pkg::result_t rpt
);
  import mtsea_pkg::*;

  cmd_head_t head;
  logic      cmd_pop;
  logic      rpt_full;
  rpt_push_t rpt_push;

  mtsea_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .evt     (evt),
    .head    (head),
    .cmd_pop (cmd_pop)
  );

  mtsea_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .cmd_pop  (cmd_pop),
    .rpt_full (rpt_full),
    .rpt_out  (rpt_push)
  );

  mtsea_out_queue u_out (
    .clk      (clk),
    .rst      (rst),
    .rpt_in   (rpt_push),
    .rpt_full (rpt_full),
    .empty    (empty),
    .pop      (pop),
    .rpt      (rpt)
  );

endmodule

// File: rtl/core/mtsea_front.sv
// mtsea_front: decodes incoming items into slot commands and queues them
// depends on mtsea_pkg
`timescale 1ns / 1ps

module mtsea_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mtsea_pkg::event_t   evt,
  output mtsea_pkg::cmd_head_t head,
  input  logic                cmd_pop
);
  import mtsea_pkg::*;

  cmd_t       cls_cmd;
  logic       cls_valid;
  logic       enq;
  logic       deq;
  cmd_t       q [2];
  logic [1:0] count;
  logic [1:0] count_next;
  logic       wr_ptr;
  logic       rd_ptr;

  // classify
  always_comb begin
    cls_valid        = 1'b0;
    cls_cmd.op       = OP_WRITE;
    cls_cmd.field    = FLD_ID;
    cls_cmd.slot_sel = evt.event_value[SLOT_W-1:0];
    cls_cmd.value    = evt.event_value;
    if (evt.event_type == EV_SYNC) begin
      if (evt.event_code == CODE_REPORT) begin
        cls_valid  = 1'b1;
        cls_cmd.op = OP_REPORT;
      end
    end else if (evt.event_type == EV_ABSOLUTE) begin
      cls_valid = 1'b1;
      unique case (evt.event_code)
        CODE_SLOT: begin
          cls_cmd.op = OP_SLOT;
          cls_valid  = !evt.event_value[31] &&
                       (evt.event_value[30:0] < 31'(NUM_SLOTS));
        end
        CODE_TRACK_ID:    cls_cmd.field = FLD_ID;
        CODE_POS_X:       cls_cmd.field = FLD_X;
        CODE_POS_Y:       cls_cmd.field = FLD_Y;
        CODE_TOUCH_MAJOR: cls_cmd.field = FLD_MAJOR;
        CODE_TOUCH_MINOR: cls_cmd.field = FLD_MINOR;
        CODE_WIDTH_MAJOR: cls_cmd.field = FLD_WMAJOR;
        CODE_WIDTH_MINOR: cls_cmd.field = FLD_WMINOR;
        CODE_ORIENTATION: cls_cmd.field = FLD_ANGLE;
        CODE_PRESSURE:    cls_cmd.field = FLD_PRESSURE;
        CODE_DISTANCE:    cls_cmd.field = FLD_DISTANCE;
        default:          cls_valid = 1'b0;
      endcase
    end
  end

  assign full = (count == 2'd2);
  assign enq  = push && !full && cls_valid;
  assign deq  = cmd_pop && (count != 2'd0);

  always_comb begin
    count_next = count;
    if (enq && !deq) begin
      count_next = count + 2'd1;
    end else if (deq && !enq) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= cls_cmd;
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = q[rd_ptr];

endmodule

// File: rtl/core/mtsea_back.sv
// mtsea_back: slot pointer, per-slot contact records and command execution
// depends on mtsea_pkg
`timescale 1ns / 1ps

module mtsea_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mtsea_pkg::cmd_head_t  head,
  output logic                  cmd_pop,
  input  logic                  rpt_full,
  output mtsea_pkg::rpt_push_t  rpt_out
);
  import mtsea_pkg::*;

  back_state_e             state;
  back_state_e             state_next;
  cmd_t                    cmd;
  logic [SLOT_W-1:0]       slot_ptr;
  logic [SLOT_W-1:0]       clr_addr;
  logic [31:0]             mem [NUM_FIELDS][NUM_SLOTS];
  logic [31:0]             rd_data [NUM_FIELDS];
  logic                    is_emit_op;
  logic                    do_emit;
  logic                    commit;
  logic                    clearing;

  // read port follows the slot pointer every cycle
  always_ff @(posedge clk) begin
    for (int f = 0; f < NUM_FIELDS; f++) begin
      rd_data[f] <= mem[f][slot_ptr];
    end
  end

  assign is_emit_op = (cmd.op == OP_REPORT) || (cmd.op == OP_SLOT);
  assign do_emit    = is_emit_op && !rd_data[FLD_ID][31];

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    commit     = 1'b0;
    clearing   = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        clearing = 1'b1;
        if (clr_addr == SLOT_W'(NUM_SLOTS - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head.valid) begin
          cmd_pop    = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!(do_emit && rpt_full)) begin
          commit     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_CLEAR;
      slot_ptr <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (commit && cmd.op == OP_SLOT) begin
        slot_ptr <= cmd.slot_sel;
      end
    end
  end

  // one write per field memory per cycle
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd <= head.cmd;
    end
    for (int f = 0; f < NUM_FIELDS; f++) begin
      if (clearing) begin
        mem[f][clr_addr] <= '1;
      end else if (commit && cmd.op == OP_WRITE && cmd.field == field_e'(f)) begin
        mem[f][slot_ptr] <= cmd.value;
      end
    end
  end

  assign rpt_out.push                 = commit && do_emit;
  assign rpt_out.rpt.slot_index       = OUT_SLOT_W'(slot_ptr);
  assign rpt_out.rpt.tracking_id      = rd_data[FLD_ID];
  assign rpt_out.rpt.pos_x            = rd_data[FLD_X];
  assign rpt_out.rpt.pos_y            = rd_data[FLD_Y];
  assign rpt_out.rpt.contact_major    = rd_data[FLD_MAJOR];
  assign rpt_out.rpt.contact_minor    = rd_data[FLD_MINOR];
  assign rpt_out.rpt.approach_major   = rd_data[FLD_WMAJOR];
  assign rpt_out.rpt.approach_minor   = rd_data[FLD_WMINOR];
  assign rpt_out.rpt.contact_angle    = rd_data[FLD_ANGLE];
  assign rpt_out.rpt.contact_pressure = rd_data[FLD_PRESSURE];
  assign rpt_out.rpt.hover_distance   = rd_data[FLD_DISTANCE];

endmodule

// File: rtl/core/mtsea_out_queue.sv
// mtsea_out_queue: two-entry queue of contact reports toward the consumer
// depends on mtsea_pkg
`timescale 1ns / 1ps

module mtsea_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  mtsea_pkg::rpt_push_t rpt_in,
  output logic                 rpt_full,
  output logic                 empty,
  input  logic                 pop,
  output mtsea_pkg::result_t   rpt
);
  import mtsea_pkg::*;

  result_t    q [2];
  logic [1:0] count;
  logic [1:0] count_next;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       enq;
  logic       deq;

  assign rpt_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign enq      = rpt_in.push && !rpt_full;
  assign deq      = pop && !empty;

  always_comb begin
    count_next = count;
    if (enq && !deq) begin
      count_next = count + 2'd1;
    end else if (deq && !enq) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= rpt_in.rpt;
    end
  end

  assign rpt = q[rd_ptr];

endmodule
